>>> hw/rtl/pcl_pkg.sv
// Shared types and constants for the prefix connection limiter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package pcl_pkg;

    // Default sizes handed down from the top level
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    // Fixed field widths
    localparam int ADDR_BITS     = 32;
    localparam int LIMIT_BITS    = 16;
    localparam int LEN_BITS      = 6;
    localparam int CLIENT_BITS   = 17;
    localparam int RESULT_BITS   = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH   = 2;

    // Longest usable IPv4 prefix
    localparam logic [LEN_BITS-1:0] MAX_PREFIX_LEN = 6'd32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PER_PREFIX_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LEN       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_LIMIT      = 2'd2;

    // Command codes
    localparam logic CMD_ATTACH = 1'b0;
    localparam logic CMD_DETACH = 1'b1;

    // Limits the back end needs from the register file
    typedef struct packed {
        logic [LIMIT_BITS-1:0] per_prefix_limit;
        logic [LIMIT_BITS-1:0] class_limit;
    } cfg_t;

    // Classified word carried from front to back
    typedef struct packed {
        logic                 cmd;
        logic                 exempt;
        logic                 was_added;
        logic                 enabled;   // prefix checking active
        logic                 scan;      // table lookup needed
        logic [ADDR_BITS-1:0] prefix;    // masked address
    } qword_t;

endpackage

`default_nettype wire

>>> hw/rtl/prefix_connection_limiter_core.sv
// Words that skip the table pass the queue slot, the back end's word register
// and the output register; a table lookup adds a scan (one entry read per cycle)
// that stops at the first matching entry. The queue takes new words while the
// back end works on one word at a time, paced by the single read port of the
// prefix table that the scan walks. Reset: counts and registers clear; the
// table is then swept clean with in_ready low (configuration writes still taken).
`default_nettype none

module prefix_connection_limiter_core
#(
    parameter int TABLE_ENTRIES = pcl_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = pcl_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire logic [pcl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [pcl_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  cmd,
    input  wire logic [pcl_pkg::ADDR_BITS-1:0]         address,
    input  wire logic                                  exempt,
    input  wire logic                                  was_added,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [pcl_pkg::RESULT_BITS-1:0]     limit_result,
    output logic                                       prefix_added,
    output logic                                       table_full
);

    pcl_pkg::cfg_t    cfg;
    pcl_pkg::qword_t  push_word;
    pcl_pkg::qword_t  pop_word;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic             clear_busy;

    // input side: registers and classification
    pcl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .address    (address),
        .exempt     (exempt),
        .was_added  (was_added),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (push_word),
        .cfg        (cfg)
    );

    // decoupling queue
    pcl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_word  (pop_word)
    );

    // table and result side
    pcl_back
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_word       (pop_word),
        .q_pop        (q_pop),
        .clear_busy   (clear_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .limit_result (limit_result),
        .prefix_added (prefix_added),
        .table_full   (table_full)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pcl_front.sv
// Front end: configuration registers, input handshake, prefix masking
// and classification of each word. Depends on pcl_pkg.
`default_nettype none

module pcl_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [pcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                cmd,
    input  wire logic [pcl_pkg::ADDR_BITS-1:0]       address,
    input  wire logic                                exempt,
    input  wire logic                                was_added,
    // toward queue and back end
    input  wire logic                                clear_busy,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output pcl_pkg::qword_t                          q_word,
    output pcl_pkg::cfg_t                            cfg
);

    logic [pcl_pkg::LIMIT_BITS-1:0] per_prefix_limit_reg;
    logic [pcl_pkg::LEN_BITS-1:0]   prefix_len_reg;
    logic [pcl_pkg::LIMIT_BITS-1:0] class_limit_reg;
    logic [pcl_pkg::LEN_BITS-1:0]   len_eff;
    logic [pcl_pkg::ADDR_BITS-1:0]  mask;
    logic                           enabled;

    // register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_prefix_limit_reg <= '0;
            prefix_len_reg       <= '0;
            class_limit_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcl_pkg::REG_PER_PREFIX_LIMIT:
                    per_prefix_limit_reg <= cfg_data;
                pcl_pkg::REG_PREFIX_LEN:
                    prefix_len_reg <= cfg_data[pcl_pkg::LEN_BITS-1:0];
                pcl_pkg::REG_CLASS_LIMIT:
                    class_limit_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // prefix mask; lengths above 32 act as 32
    always_comb
    begin
        len_eff = (prefix_len_reg > pcl_pkg::MAX_PREFIX_LEN) ?
                  pcl_pkg::MAX_PREFIX_LEN : prefix_len_reg;
        if (len_eff == '0)
            mask = '0;
        else
            mask = {pcl_pkg::ADDR_BITS{1'b1}} << (pcl_pkg::MAX_PREFIX_LEN - len_eff);
    end

    assign enabled = (per_prefix_limit_reg != '0) && (prefix_len_reg != '0);

    // classify: with checking enabled, attaches always look up, detaches only if counted
    always_comb
    begin
        q_word.cmd       = cmd;
        q_word.exempt    = exempt;
        q_word.was_added = was_added;
        q_word.enabled   = enabled;
        q_word.scan      = enabled && ((cmd == pcl_pkg::CMD_ATTACH) || was_added);
        q_word.prefix    = address & mask;
    end

    // no words taken while the table is being cleared
    assign in_ready = !q_full && !clear_busy;
    assign q_push   = in_valid && in_ready;

    assign cfg.per_prefix_limit = per_prefix_limit_reg;
    assign cfg.class_limit      = class_limit_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pcl_queue.sv
// Short queue between the front end and the back end.
// Depends on pcl_pkg for the word type and depth.
`default_nettype none

module pcl_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pcl_pkg::qword_t push_word,
    output logic                 full,
    input  wire logic            pop,
    output logic                 pop_valid,
    output pcl_pkg::qword_t      pop_word
);

    localparam int QAW = (pcl_pkg::QUEUE_DEPTH > 1) ? $clog2(pcl_pkg::QUEUE_DEPTH) : 1;
    localparam logic [QAW-1:0] LAST_PTR = QAW'(pcl_pkg::QUEUE_DEPTH - 1);
    localparam logic [QAW:0]   DEPTH_CNT = (QAW + 1)'(pcl_pkg::QUEUE_DEPTH);

    pcl_pkg::qword_t  slot_reg [pcl_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_word  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

endmodule

`default_nettype wire

>>> hw/rtl/pcl_back.sv
// Back end: prefix table memory, table scan, count updates and the
// output register. Clears the table after reset. Depends on pcl_pkg.
`default_nettype none

module pcl_back
#(
    parameter int TABLE_ENTRIES = pcl_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = pcl_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pcl_pkg::cfg_t                         cfg,
    // queue side
    input  wire logic                                  q_valid,
    input  wire pcl_pkg::qword_t                       q_word,
    output logic                                       q_pop,
    output logic                                       clear_busy,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [pcl_pkg::RESULT_BITS-1:0]     limit_result,
    output logic                                       prefix_added,
    output logic                                       table_full
);

    localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PW   = pcl_pkg::ADDR_BITS;
    localparam int WW   = 1 + PW + COUNT_BITS;
    localparam int CMPW = (COUNT_BITS > pcl_pkg::LIMIT_BITS) ? COUNT_BITS : pcl_pkg::LIMIT_BITS;
    localparam int CB   = pcl_pkg::CLIENT_BITS;
    localparam int RB   = pcl_pkg::RESULT_BITS;

    localparam logic [AW-1:0]         LAST_IDX   = AW'(TABLE_ENTRIES - 1);
    localparam logic [AW:0]           SCAN_END   = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
    localparam logic [CB-1:0]         CLIENT_MAX = {CB{1'b1}};

    // state codes
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [AW-1:0]          clr_idx_reg;
    logic [AW-1:0]          clr_idx_next;
    logic [AW:0]            scan_cnt_reg;
    logic [AW:0]            scan_cnt_next;
    logic                   chk_vld_reg;
    logic                   chk_vld_next;
    logic [AW-1:0]          chk_idx_reg;
    logic [AW-1:0]          chk_idx_next;
    logic                   match_reg;
    logic                   match_next;
    logic [AW-1:0]          match_idx_reg;
    logic [AW-1:0]          match_idx_next;
    logic [COUNT_BITS-1:0]  match_cnt_reg;
    logic [COUNT_BITS-1:0]  match_cnt_next;
    logic                   free_found_reg;
    logic                   free_found_next;
    logic [AW-1:0]          free_idx_reg;
    logic [AW-1:0]          free_idx_next;
    pcl_pkg::qword_t        item_reg;
    logic [CB-1:0]          client_count_reg;
    logic [CB-1:0]          client_count_next;
    logic                   out_valid_reg;
    logic signed [RB-1:0]   limit_result_reg;
    logic                   prefix_added_reg;
    logic                   table_full_reg;

    // table memory
    logic [WW-1:0]          mem [TABLE_ENTRIES];
    logic [WW-1:0]          rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WW-1:0]          wr_data;

    // scan and update signals
    logic                   e_valid;
    logic [PW-1:0]          e_prefix;
    logic [COUNT_BITS-1:0]  e_count;
    logic                   e_hit;
    logic                   issue;
    logic                   commit;
    logic                   is_det;
    logic [CB-1:0]          cc_inc;
    logic [CB-1:0]          cc_dec;
    logic                   class_hit;
    logic                   cnt_ge;
    logic                   refused;
    logic                   prefix_hit;
    logic                   full_hit;
    logic                   added;
    logic [1:0]             hits;
    logic [RB-1:0]          hits_ext;
    logic [RB-1:0]          result_val;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  cnt_dec;

    assign clear_busy = (state_reg == ST_CLEAR);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign commit     = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    // fields of the entry read last cycle
    assign e_valid  = rd_data_reg[WW-1];
    assign e_prefix = rd_data_reg[WW-2 -: PW];
    assign e_count  = rd_data_reg[COUNT_BITS-1:0];
    assign e_hit    = e_valid && (e_prefix == item_reg.prefix);

    assign issue   = (state_reg == ST_SCAN) && (scan_cnt_reg != SCAN_END);
    assign rd_en   = issue;
    assign rd_addr = scan_cnt_reg[AW-1:0];

    // decision for the current word
    always_comb
    begin
        is_det     = (item_reg.cmd == pcl_pkg::CMD_DETACH);
        cc_inc     = (client_count_reg == CLIENT_MAX) ? client_count_reg
                                                      : client_count_reg + 1'b1;
        cc_dec     = (client_count_reg == '0) ? client_count_reg
                                              : client_count_reg - 1'b1;
        class_hit  = !is_det && (cc_inc > {1'b0, cfg.class_limit});
        cnt_ge     = (CMPW'(match_cnt_reg) >= CMPW'(cfg.per_prefix_limit));
        refused    = !item_reg.exempt && cnt_ge;
        prefix_hit = !is_det && item_reg.enabled && match_reg && refused;
        full_hit   = !is_det && item_reg.enabled && !match_reg && !free_found_reg;
        added      = !is_det && item_reg.enabled &&
                     (match_reg ? !refused : free_found_reg);
        hits       = {1'b0, class_hit} + {1'b0, prefix_hit || full_hit};
        hits_ext   = {1'b0, hits};
        result_val = (item_reg.exempt && !is_det) ? (~hits_ext + 1'b1) : hits_ext;
        cnt_inc    = (match_cnt_reg == COUNT_MAX) ? match_cnt_reg
                                                  : match_cnt_reg + 1'b1;
        cnt_dec    = (match_cnt_reg == '0) ? match_cnt_reg : match_cnt_reg - 1'b1;
    end

    // table write: clearing pass, or at most one entry per committed word
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = match_idx_reg;
        wr_data = {1'b1, item_reg.prefix, cnt_inc};
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else if (commit && item_reg.enabled)
        begin
            if (is_det)
            begin
                // drop the entry when its count reaches zero
                wr_en   = item_reg.was_added && match_reg;
                wr_data = {(cnt_dec != '0), item_reg.prefix, cnt_dec};
            end
            else if (match_reg)
            begin
                wr_en = !refused;
            end
            else
            begin
                wr_en   = free_found_reg;
                wr_addr = free_idx_reg;
                wr_data = {1'b1, item_reg.prefix, COUNT_ONE};
            end
        end
    end

    // sequencer: clear, take a word, scan, update
    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        scan_cnt_next     = scan_cnt_reg;
        chk_vld_next      = 1'b0;
        chk_idx_next      = chk_idx_reg;
        match_next        = match_reg;
        match_idx_next    = match_idx_reg;
        match_cnt_next    = match_cnt_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        client_count_next = client_count_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                match_next      = 1'b0;
                free_found_next = 1'b0;
                scan_cnt_next   = '0;
                if (q_valid)
                    state_next = q_word.scan ? ST_SCAN : ST_UPDATE;
            end
            ST_SCAN:
            begin
                if (issue)
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                chk_vld_next = issue;
                chk_idx_next = rd_addr;
                if (chk_vld_reg)
                begin
                    if (e_hit)
                    begin
                        // lowest matching entry wins, stop here
                        match_next     = 1'b1;
                        match_idx_next = chk_idx_reg;
                        match_cnt_next = e_count;
                        chk_vld_next   = 1'b0;
                        state_next     = ST_UPDATE;
                    end
                    else
                    begin
                        if (!e_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST_IDX)
                            state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    client_count_next = is_det ? cc_dec : cc_inc;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            chk_vld_reg      <= 1'b0;
            client_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            chk_vld_reg      <= chk_vld_next;
            client_count_reg <= client_count_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // scan bookkeeping and payload, no reset
    always_ff @(posedge clk)
    begin
        scan_cnt_reg   <= scan_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        match_cnt_reg  <= match_cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        if (q_pop)
            item_reg <= q_word;
        if (commit)
        begin
            limit_result_reg <= result_val;
            prefix_added_reg <= added;
            table_full_reg   <= full_hit;
        end
    end

    // table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    assign out_valid    = out_valid_reg;
    assign limit_result = limit_result_reg;
    assign prefix_added = prefix_added_reg;
    assign table_full   = table_full_reg;

    // checks
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("table written during scan");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !q_pop)
        else $error("word taken while clearing table");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_full_not_added: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && table_full_reg |-> !prefix_added_reg)
        else $error("table_full with prefix_added");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(client_count_reg))
        else $error("client count moved without a commit");

endmodule

`default_nettype wire
